// ----- hw/rtl/mm3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3_pkg
// Shared constants and types for the 3x3 integer matrix multiplier.
// ----------------------------------------------------------------------------
package mm3_pkg;

  localparam int DIM_DEFAULT        = 3;
  localparam int ELEM_WIDTH_DEFAULT = 16;

  localparam int PROD_WIDTH  = 33;
  localparam int IDX_WIDTH   = 2;
  localparam int OUT_FIELD_W = PROD_WIDTH + 2 * IDX_WIDTH;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

// ----- hw/rtl/mm3_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3_store
// Matrix element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mm3_store #(
  parameter int DEPTH = 9,
  parameter int WIDTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/mm3_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3_mac
// Shared multiply-accumulate unit: registered product, then 33-bit wrapping
// accumulate. Clears on the first term, flags done after the last term.
// ----------------------------------------------------------------------------
module mm3_mac
  import mm3_pkg::*;
#(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mac_ctl_t              ctl,
  input  logic [ELEM_WIDTH-1:0] a,
  input  logic [ELEM_WIDTH-1:0] b,
  output logic [PROD_WIDTH-1:0] acc,
  output logic                  done
);

  logic signed [2*ELEM_WIDTH-1:0] prod;
  logic signed [63:0]             prod_wide;
  logic [PROD_WIDTH-1:0]          prod_ext;
  mac_ctl_t                       ctl_p;

  always_ff @(posedge clk) begin
    prod <= $signed(a) * $signed(b);
  end

  assign prod_wide = 64'(prod);
  assign prod_ext  = prod_wide[PROD_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_p <= '0;
      done  <= 1'b0;
    end else begin
      ctl_p <= ctl;
      done  <= ctl_p.valid && ctl_p.last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_p.valid) begin
      acc <= ctl_p.first ? prod_ext : acc + prod_ext;
    end
  end

endmodule

// ----- hw/rtl/matrix_multiply_3x3.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_3x3
// Streams in A then B row-major, streams out A*B row-major at full precision.
// ----------------------------------------------------------------------------
// Input words load one per cycle: the first DIM*DIM fill A, the next DIM*DIM
// fill B. After the last B word the block stops taking input and computes
// the product entries one at a time on a single shared multiply-accumulate
// unit, DIM terms per entry. Each entry passes through the store reads, the
// registered multiply and the accumulate, then goes out as one output word;
// a stalled output holds it. Output words carry the row and column; tlast
// marks the last entry.
module matrix_multiply_3x3
  import mm3_pkg::*;
#(
  parameter int  DIM        = DIM_DEFAULT,
  parameter int  ELEM_WIDTH = ELEM_WIDTH_DEFAULT,
  localparam int IN_TDATA_W = ((ELEM_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // element_value
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // product_value, row_index, column_index
  output logic                   m_axis_tlast   // last_entry
);

  localparam int CELLS = DIM * DIM;
  localparam int CW    = $clog2(CELLS);
  localparam int LW    = $clog2(2 * CELLS);
  localparam int IW    = $clog2(DIM);
  localparam int PAD_W = OUT_TDATA_W - OUT_FIELD_W;

  typedef enum logic [2:0] {
    S_LOAD = 3'b001,
    S_CALC = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                state;
  logic [LW-1:0]         load_cnt;
  logic [IW-1:0]         row_q;
  logic [IW-1:0]         col_q;
  logic [IW-1:0]         k_q;
  logic                  issuing;
  mac_ctl_t              rd_ctl;
  mac_ctl_t              issue_ctl;

  logic [PROD_WIDTH-1:0] out_product;
  logic [IDX_WIDTH-1:0]  out_row;
  logic [IDX_WIDTH-1:0]  out_col;
  logic                  out_last;

  logic                  in_acc;
  logic                  load_a;
  logic                  load_b;
  logic [CW-1:0]         a_wr_addr;
  logic [CW-1:0]         b_wr_addr;
  logic [LW-1:0]         b_offset;
  logic [CW-1:0]         a_rd_addr;
  logic [CW-1:0]         b_rd_addr;
  logic [ELEM_WIDTH-1:0] a_data;
  logic [ELEM_WIDTH-1:0] b_data;
  logic [PROD_WIDTH-1:0] acc;
  logic                  mac_done;
  logic                  entry_last;
  logic [31:0]           row_ext;
  logic [31:0]           col_ext;

  assign s_axis_tready = (state == S_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign load_a        = in_acc && (load_cnt < LW'(CELLS));
  assign load_b        = in_acc && (load_cnt >= LW'(CELLS));
  assign a_wr_addr     = load_cnt[CW-1:0];
  assign b_offset      = load_cnt - LW'(CELLS);
  assign b_wr_addr     = b_offset[CW-1:0];

  assign a_rd_addr = CW'(int'(row_q) * DIM + int'(k_q));
  assign b_rd_addr = CW'(int'(k_q) * DIM + int'(col_q));

  assign entry_last = (row_q == IW'(DIM - 1)) && (col_q == IW'(DIM - 1));
  assign row_ext    = 32'(row_q);
  assign col_ext    = 32'(col_q);

  always_comb begin
    issue_ctl.valid = (state == S_CALC) && issuing;
    issue_ctl.first = (k_q == '0);
    issue_ctl.last  = (k_q == IW'(DIM - 1));
  end

  mm3_store #(
    .DEPTH (CELLS),
    .WIDTH (ELEM_WIDTH),
    .AW    (CW)
  ) u_store_a (
    .clk     (clk),
    .wr_en   (load_a),
    .wr_addr (a_wr_addr),
    .wr_data (s_axis_tdata[ELEM_WIDTH-1:0]),
    .rd_addr (a_rd_addr),
    .rd_data (a_data)
  );

  mm3_store #(
    .DEPTH (CELLS),
    .WIDTH (ELEM_WIDTH),
    .AW    (CW)
  ) u_store_b (
    .clk     (clk),
    .wr_en   (load_b),
    .wr_addr (b_wr_addr),
    .wr_data (s_axis_tdata[ELEM_WIDTH-1:0]),
    .rd_addr (b_rd_addr),
    .rd_data (b_data)
  );

  mm3_mac #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rd_ctl),
    .a    (a_data),
    .b    (b_data),
    .acc  (acc),
    .done (mac_done)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      load_cnt <= '0;
      row_q    <= '0;
      col_q    <= '0;
      k_q      <= '0;
      issuing  <= 1'b0;
      rd_ctl   <= '0;
    end else begin
      rd_ctl <= issue_ctl;
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (load_cnt == LW'(2 * CELLS - 1)) begin
              load_cnt <= '0;
              row_q    <= '0;
              col_q    <= '0;
              k_q      <= '0;
              issuing  <= 1'b1;
              state    <= S_CALC;
            end else begin
              load_cnt <= load_cnt + 1'b1;
            end
          end
        end
        S_CALC: begin
          if (issuing) begin
            if (k_q == IW'(DIM - 1)) begin
              issuing <= 1'b0;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end
          if (mac_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (m_axis_tready) begin
            k_q <= '0;
            if (entry_last) begin
              state <= S_LOAD;
            end else begin
              issuing <= 1'b1;
              state   <= S_CALC;
              if (col_q == IW'(DIM - 1)) begin
                col_q <= '0;
                row_q <= row_q + 1'b1;
              end else begin
                col_q <= col_q + 1'b1;
              end
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (state == S_CALC && mac_done) begin
      out_product <= acc;
      out_row     <= row_ext[IDX_WIDTH-1:0];
      out_col     <= col_ext[IDX_WIDTH-1:0];
      out_last    <= entry_last;
    end
  end

  assign m_axis_tvalid = (state == S_EMIT);
  assign m_axis_tdata  = {PAD_W'(0), out_col, out_row, out_product};
  assign m_axis_tlast  = out_last;

endmodule

// ----- tb/matrix_multiply_3x3_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_3x3_tb
// Self-checking bench for the streaming 3x3 integer matrix multiplier.
// ----------------------------------------------------------------------------
// Words are fed as A then B, row-major. A behavioral product model keeps its
// own copy of both matrices and queues the nine product entries expected when
// B completes. Every output word is checked against the oldest queued entry.
// Runs cover full-scale products, random data, corner-value data and
// back-to-back traffic; the other runs add random gaps and stalls on both sides.
module matrix_multiply_3x3_tb;
  import mm3_pkg::*;

  localparam int N          = 3;
  localparam int CELLS      = N * N;
  localparam int EW         = 16;
  localparam int IN_W       = ((EW + 7) / 8) * 8;
  localparam int MAX_GAP    = 17;
  localparam int DRAIN_WAIT = 100;
  localparam int CYCLE_CAP  = 200000;
  localparam int MAX_SHOWN  = 10;

  typedef struct packed {
    logic signed [PROD_WIDTH-1:0] product;
    logic [IDX_WIDTH-1:0]         row;
    logic [IDX_WIDTH-1:0]         col;
    logic                         last;
  } product_entry_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  logic signed [EW-1:0] a_mat [CELLS];
  logic signed [EW-1:0] b_mat [CELLS];
  int                   load_pos;
  product_entry_t       pending_products [$];

  bit in_idle;
  bit out_idle;
  int stall_left;
  int out_gap;
  int error_count;
  int entries_checked;
  int words_sent;
  int runs_done;
  int cycle_count;

  matrix_multiply_3x3 DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Product model: store the word, emit A*B once B is complete.
  task automatic load_and_multiply(input logic signed [EW-1:0] value);
    longint         acc;
    product_entry_t entry;
    if (load_pos < CELLS) a_mat[load_pos] = value;
    else b_mat[load_pos - CELLS] = value;
    load_pos++;
    if (load_pos == 2 * CELLS) begin
      load_pos = 0;
      runs_done++;
      for (int r = 0; r < N; r++) begin
        for (int c = 0; c < N; c++) begin
          acc = 0;
          for (int k = 0; k < N; k++) begin
            acc += longint'(a_mat[r * N + k]) * longint'(b_mat[k * N + c]);
          end
          entry.product = acc[PROD_WIDTH-1:0];
          entry.row     = IDX_WIDTH'(r);
          entry.col     = IDX_WIDTH'(c);
          entry.last    = (r == N - 1) && (c == N - 1);
          pending_products.push_back(entry);
        end
      end
    end
  endtask

  task automatic send_word(input logic signed [EW-1:0] value);
    int gap;
    gap = in_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
    load_and_multiply(value);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_products.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [EW-1:0] draw_word(input bit corner);
    if (!corner) return EW'($urandom_range(0, 65535));
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'sh0001;
      4: return 16'shffff;
      default: return EW'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic check_entry();
    product_entry_t got;
    product_entry_t want;
    got.product = m_axis_tdata[PROD_WIDTH-1:0];
    got.row     = m_axis_tdata[PROD_WIDTH +: IDX_WIDTH];
    got.col     = m_axis_tdata[PROD_WIDTH + IDX_WIDTH +: IDX_WIDTH];
    got.last    = m_axis_tlast;
    entries_checked++;
    if (pending_products.size() == 0) begin
      if (error_count < MAX_SHOWN)
        $display("ERROR: unexpected word product=%0d row=%0d col=%0d last=%0b",
                 got.product, got.row, got.col, got.last);
      error_count++;
      return;
    end
    want = pending_products.pop_front();
    if (got.product !== want.product || got.row !== want.row ||
        got.col !== want.col || got.last !== want.last) begin
      if (error_count < MAX_SHOWN)
        $display("ERROR: exp product=%0d row=%0d col=%0d last=%0b, got %0d %0d %0d %0b",
                 want.product, want.row, want.col, want.last,
                 got.product, got.row, got.col, got.last);
      error_count++;
    end
  endtask

  // Output side: check each word, then stall for a random gap when out_idle is set.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      check_entry();
      out_gap = out_idle ? $urandom_range(0, MAX_GAP) : 0;
      stall_left    <= out_gap;
      m_axis_tready <= (out_gap == 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left    <= 0;
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("ERROR: timeout after %0d cycles", cycle_count);
      $display("matrix_multiply_3x3_tb: done, errors");
      $finish;
    end
  end

  // Full-scale entries: min*min gives the largest product, min*max the most
  // negative one; the last row and column mix small values.
  task automatic test_full_scale();
    logic signed [EW-1:0] mix [N];
    mix = '{16'sh0001, 16'shffff, 16'sh0000};
    in_idle  = 1'b1;
    out_idle = 1'b1;
    for (int i = 0; i < N; i++) send_word(16'sh8000);
    for (int i = 0; i < N; i++) send_word(16'sh7fff);
    for (int i = 0; i < N; i++) send_word(mix[i]);
    for (int k = 0; k < N; k++) begin
      send_word(16'sh8000);
      send_word(16'sh7fff);
      send_word(mix[(k + 1) % N]);
    end
    wait_drained();
  endtask

  task automatic test_random_runs(input int runs);
    for (int r = 0; r < runs; r++) begin
      in_idle  = (r % 4) != 3;
      out_idle = (r % 3) != 2;
      for (int i = 0; i < 2 * CELLS; i++) send_word(draw_word(1'b0));
      if (r == runs / 2) wait_drained();
    end
  endtask

  task automatic test_corner_runs(input int runs);
    in_idle  = 1'b1;
    out_idle = 1'b1;
    for (int r = 0; r < runs; r++) begin
      for (int i = 0; i < 2 * CELLS; i++) send_word(draw_word(1'b1));
    end
  endtask

  task automatic test_back_to_back(input int runs);
    in_idle  = 1'b0;
    out_idle = 1'b0;
    for (int r = 0; r < runs; r++) begin
      for (int i = 0; i < 2 * CELLS; i++) send_word(draw_word(r[0]));
    end
    wait_drained();
  endtask

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    in_idle       = 1'b0;
    out_idle      = 1'b0;
    load_pos      = 0;
    words_sent    = 0;
    runs_done     = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_full_scale();
    test_random_runs(8);
    test_corner_runs(4);
    test_back_to_back(2);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d words in %0d matrix pairs, checked %0d product words.",
             words_sent, runs_done, entries_checked);
    $display("Data: full-scale, random and corner values; gaps and stalls on both sides.");
    if (error_count == 0) begin
      $display("matrix_multiply_3x3_tb: done, clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("matrix_multiply_3x3_tb: done, errors");
    end
    $finish;
  end

endmodule
